// File: src/ras_pkg.sv
// Shared types and constants for the rectangular assignment solver.
// Used by the controller, the datapath and the top level; depends on nothing.
package ras_pkg;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE       = 4'd0;
    localparam op_t OP_LOAD       = 4'd1;
    localparam op_t OP_CLEAR      = 4'd2;
    localparam op_t OP_MIN_INIT   = 4'd3;
    localparam op_t OP_RED_MIN    = 4'd4;
    localparam op_t OP_RED_SUB    = 4'd5;
    localparam op_t OP_CLR_ROWCOV = 4'd6;
    localparam op_t OP_ADJ_MIN    = 4'd7;
    localparam op_t OP_ADJ_T      = 4'd8;
    localparam op_t OP_ADJ_WR     = 4'd9;
    localparam op_t OP_PRIME      = 4'd10;
    localparam op_t OP_AUG_STEP   = 4'd11;
    localparam op_t OP_REB_CLR    = 4'd12;
    localparam op_t OP_REB        = 4'd13;
    localparam op_t OP_TOT_CLR    = 4'd14;
    localparam op_t OP_EMIT       = 4'd15;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

    typedef struct packed {
        op_t  op;
        logic col_mode;
        logic out_addr;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic col_cov;
        logic row_cov;
        logic rd_zero;
        logic row_star;
        logic cover_done;
        logic map_v;
        logic map_prime_v;
        logic out_free;
    } stat_t;

endpackage

// File: src/ras_dp.sv
// Datapath of the assignment solver: cost memories, star, prime and cover marks,
// minimum and adjust arithmetic, and the result register. Depends on ras_pkg.
module ras_dp
    import ras_pkg::*;
#(
    parameter int MAX_DIM   = 16,
    parameter int COST_BITS = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    input  logic [$clog2(MAX_DIM)-1:0]   r,
    input  logic [$clog2(MAX_DIM)-1:0]   c,
    input  logic [$clog2(MAX_DIM+1)-1:0] min_dim,
    input  logic [COST_BITS-1:0]         cost,
    output stat_t                        stat,
    output logic [$clog2(MAX_DIM)-1:0]   map_prime_col,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [3:0]                   row_index,
    output logic [3:0]                   assigned_column,
    output logic                         is_assigned,
    output logic [19:0]                  total_cost,
    output logic                         last_row
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int AW     = 2 * IDX_W;
    localparam int DEPTH  = 1 << AW;
    localparam int WORK_W = COST_BITS + 8;
    localparam int SUM_W  = (COST_BITS > 20 ? COST_BITS : 20) + 1;
    localparam logic [WORK_W-1:0] WORK_MAX = '1;

    logic [COST_BITS-1:0] orig_mem [DEPTH];
    logic [WORK_W-1:0]    work_mem [DEPTH];
    logic [COST_BITS-1:0] orig_rd_reg;
    logic [WORK_W-1:0]    work_rd_reg;

    logic [IDX_W-1:0] star_col_reg [MAX_DIM];
    logic [IDX_W-1:0] prime_col_reg [MAX_DIM];
    logic [IDX_W-1:0] map_row_reg [MAX_DIM];
    logic [MAX_DIM-1:0] star_v_reg, prime_v_reg, map_v_reg, row_cov_reg, col_cov_reg;
    logic [DIM_W-1:0] cov_cnt_reg;

    logic [WORK_W-1:0] h_reg, t_reg;
    logic [19:0] total_reg, total_next;
    logic out_valid_reg;
    logic [3:0] row_index_reg, col_out_reg;
    logic is_assigned_reg, last_row_reg;
    logic [19:0] total_out_reg;

    logic [AW-1:0] addr;
    logic work_we;
    logic [WORK_W-1:0] work_wd;
    logic [WORK_W:0] sat_sum;
    logic [WORK_W-1:0] sat_add, sub_floor;
    logic [SUM_W-1:0] tot_sum;
    logic [IDX_W-1:0] sr, sc_star;
    logic starable;

    assign addr    = {r, cmd.out_addr ? star_col_reg[r] : c};
    assign sat_sum = {1'b0, work_rd_reg} + {1'b0, h_reg};
    assign sat_add = sat_sum[WORK_W] ? WORK_MAX : sat_sum[WORK_W-1:0];
    assign sub_floor = (t_reg < h_reg) ? '0 : t_reg - h_reg;
    assign sr = map_row_reg[c];
    assign sc_star = star_col_reg[r];
    assign starable = cmd.col_mode ? (!row_cov_reg[r] && !map_v_reg[c])
                                   : (!col_cov_reg[c] && !star_v_reg[r]);

    always_comb
    begin
        work_we = 1'b0;
        work_wd = work_rd_reg - h_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                work_we = 1'b1;
                work_wd = WORK_W'(cost);
            end
            OP_RED_SUB:
            begin
                work_we = 1'b1;
            end
            OP_ADJ_WR:
            begin
                work_we = 1'b1;
                work_wd = col_cov_reg[c] ? t_reg : sub_floor;
            end
            default:
            begin
                work_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            orig_mem[addr] <= cost;
        end
        if (work_we)
        begin
            work_mem[addr] <= work_wd;
        end
        orig_rd_reg <= orig_mem[addr];
        work_rd_reg <= work_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star_v_reg  <= '0;
            prime_v_reg <= '0;
            map_v_reg   <= '0;
            row_cov_reg <= '0;
            col_cov_reg <= '0;
            cov_cnt_reg <= '0;
            for (int i = 0; i < MAX_DIM; i++)
            begin
                star_col_reg[i]  <= '0;
                prime_col_reg[i] <= '0;
                map_row_reg[i]   <= '0;
            end
        end
        else
        begin
            unique case (cmd.op)
                OP_CLEAR:
                begin
                    star_v_reg  <= '0;
                    prime_v_reg <= '0;
                    map_v_reg   <= '0;
                    row_cov_reg <= '0;
                    col_cov_reg <= '0;
                    cov_cnt_reg <= '0;
                end
                OP_RED_SUB:
                begin
                    if (work_rd_reg == h_reg && starable)
                    begin
                        star_v_reg[r]   <= 1'b1;
                        star_col_reg[r] <= c;
                        map_v_reg[c]    <= 1'b1;
                        map_row_reg[c]  <= r;
                        col_cov_reg[c]  <= 1'b1;
                        cov_cnt_reg     <= cov_cnt_reg + 1'b1;
                        if (cmd.col_mode)
                        begin
                            row_cov_reg[r] <= 1'b1;
                        end
                    end
                end
                OP_CLR_ROWCOV:
                begin
                    row_cov_reg <= '0;
                end
                OP_PRIME:
                begin
                    prime_v_reg[r]   <= 1'b1;
                    prime_col_reg[r] <= c;
                    if (star_v_reg[r])
                    begin
                        row_cov_reg[r]       <= 1'b1;
                        col_cov_reg[sc_star] <= 1'b0;
                    end
                    else
                    begin
                        star_v_reg[r]   <= 1'b1;
                        star_col_reg[r] <= c;
                    end
                end
                OP_AUG_STEP:
                begin
                    if (map_v_reg[c])
                    begin
                        if (prime_v_reg[sr])
                        begin
                            star_col_reg[sr] <= prime_col_reg[sr];
                        end
                        else
                        begin
                            star_v_reg[sr] <= 1'b0;
                        end
                    end
                end
                OP_REB_CLR:
                begin
                    prime_v_reg <= '0;
                    map_v_reg   <= '0;
                    row_cov_reg <= '0;
                    col_cov_reg <= '0;
                    cov_cnt_reg <= '0;
                end
                OP_REB:
                begin
                    if (star_v_reg[r])
                    begin
                        map_v_reg[sc_star]   <= 1'b1;
                        map_row_reg[sc_star] <= r;
                        col_cov_reg[sc_star] <= 1'b1;
                        cov_cnt_reg          <= cov_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign tot_sum = SUM_W'(total_reg) + (star_v_reg[r] ? SUM_W'(orig_rd_reg) : '0);
    assign total_next = (tot_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[19:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg         <= '0;
            t_reg         <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_MIN_INIT:
                begin
                    h_reg <= WORK_MAX;
                end
                OP_RED_MIN:
                begin
                    if (work_rd_reg < h_reg)
                    begin
                        h_reg <= work_rd_reg;
                    end
                end
                OP_ADJ_MIN:
                begin
                    if (!row_cov_reg[r] && !col_cov_reg[c] && work_rd_reg < h_reg)
                    begin
                        h_reg <= work_rd_reg;
                    end
                end
                OP_ADJ_T:
                begin
                    t_reg <= row_cov_reg[r] ? sat_add : work_rd_reg;
                end
                OP_TOT_CLR:
                begin
                    total_reg <= '0;
                end
                OP_EMIT:
                begin
                    total_reg <= total_next;
                end
                default:
                begin
                end
            endcase
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            row_index_reg   <= 4'(r);
            col_out_reg     <= star_v_reg[r] ? 4'(sc_star) : 4'd0;
            is_assigned_reg <= star_v_reg[r];
            total_out_reg   <= cmd.last ? total_next : 20'd0;
            last_row_reg    <= cmd.last;
        end
    end

    assign stat.col_cov     = col_cov_reg[c];
    assign stat.row_cov     = row_cov_reg[r];
    assign stat.rd_zero     = (work_rd_reg == '0);
    assign stat.row_star    = star_v_reg[r];
    assign stat.cover_done  = (cov_cnt_reg >= min_dim);
    assign stat.map_v       = map_v_reg[c];
    assign stat.map_prime_v = prime_v_reg[sr];
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign map_prime_col    = prime_col_reg[sr];

    assign out_valid       = out_valid_reg;
    assign row_index       = row_index_reg;
    assign assigned_column = col_out_reg;
    assign is_assigned     = is_assigned_reg;
    assign total_cost      = total_out_reg;
    assign last_row        = last_row_reg;

endmodule

// File: src/ras_ctrl.sv
// Controller of the assignment solver: load counters and the solve sequencer
// that steps the datapath through the matrix. Depends on ras_pkg.
module ras_ctrl
    import ras_pkg::*;
#(
    parameter int MAX_DIM = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(MAX_DIM+1)-1:0] nr,
    input  logic [$clog2(MAX_DIM+1)-1:0] nc,
    input  logic                         cfg_wr,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  stat_t                        stat,
    input  logic [$clog2(MAX_DIM)-1:0]   map_prime_col,
    output cmd_t                         cmd,
    output logic [$clog2(MAX_DIM)-1:0]   r,
    output logic [$clog2(MAX_DIM)-1:0]   c,
    output logic [$clog2(MAX_DIM+1)-1:0] min_dim
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_RMIN    = 4'd2;
    localparam logic [3:0] S_RSUB    = 4'd3;
    localparam logic [3:0] S_REND    = 4'd4;
    localparam logic [3:0] S_COUNT   = 4'd5;
    localparam logic [3:0] S_PRIME   = 4'd6;
    localparam logic [3:0] S_ADJ_MIN = 4'd7;
    localparam logic [3:0] S_ADJ_UPD = 4'd8;
    localparam logic [3:0] S_AUG     = 4'd9;
    localparam logic [3:0] S_REB_CLR = 4'd10;
    localparam logic [3:0] S_REB     = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [IDX_W-1:0] r_reg, r_next, c_reg, c_next;
    logic [1:0] ph_reg, ph_next;
    logic found_reg, found_next;

    logic col_mode, r_last, c_last, inner_last, outer_last, inner0;

    assign col_mode   = (nr > nc);
    assign min_dim    = col_mode ? nc : nr;
    assign r_last     = (DIM_W'(r_reg) == nr - 1'b1);
    assign c_last     = (DIM_W'(c_reg) == nc - 1'b1);
    assign inner_last = col_mode ? r_last : c_last;
    assign outer_last = col_mode ? c_last : r_last;
    assign inner0     = col_mode ? (r_reg == '0) : (c_reg == '0);
    assign in_ready   = (state_reg == S_LOAD);
    assign r = r_reg;
    assign c = c_reg;

    always_comb
    begin
        logic adv_col;
        logic fnd;
        adv_col      = 1'b0;
        fnd          = found_reg;
        state_next   = state_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        ph_next      = ph_reg;
        found_next   = found_reg;
        cmd.op       = OP_NONE;
        cmd.col_mode = col_mode;
        cmd.out_addr = 1'b0;
        cmd.last     = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (c_last)
                    begin
                        c_next = '0;
                        if (r_last)
                        begin
                            r_next     = '0;
                            state_next = S_CLR;
                        end
                        else
                        begin
                            r_next = r_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                if (cfg_wr)
                begin
                    r_next     = '0;
                    c_next     = '0;
                    state_next = S_LOAD;
                end
            end
            S_CLR:
            begin
                cmd.op     = OP_CLEAR;
                r_next     = '0;
                c_next     = '0;
                ph_next    = 2'd0;
                state_next = S_RMIN;
            end
            S_RMIN:
            begin
                if (ph_reg == 2'd0)
                begin
                    if (inner0)
                    begin
                        cmd.op = OP_MIN_INIT;
                    end
                    ph_next = 2'd1;
                end
                else
                begin
                    cmd.op  = OP_RED_MIN;
                    ph_next = 2'd0;
                    if (inner_last)
                    begin
                        if (col_mode) r_next = '0; else c_next = '0;
                        state_next = S_RSUB;
                    end
                    else if (col_mode)
                    begin
                        r_next = r_reg + 1'b1;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            S_RSUB:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    cmd.op  = OP_RED_SUB;
                    ph_next = 2'd0;
                    if (inner_last)
                    begin
                        if (col_mode) r_next = '0; else c_next = '0;
                        if (outer_last)
                        begin
                            if (col_mode) c_next = '0; else r_next = '0;
                            state_next = S_REND;
                        end
                        else
                        begin
                            if (col_mode) c_next = c_reg + 1'b1;
                            else r_next = r_reg + 1'b1;
                            state_next = S_RMIN;
                        end
                    end
                    else if (col_mode)
                    begin
                        r_next = r_reg + 1'b1;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            S_REND:
            begin
                cmd.op     = OP_CLR_ROWCOV;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                r_next  = '0;
                c_next  = '0;
                ph_next = 2'd0;
                if (stat.cover_done)
                begin
                    cmd.op     = OP_TOT_CLR;
                    state_next = S_OUT;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    ph_next = 2'd0;
                    if (stat.col_cov)
                    begin
                        adv_col = 1'b1;
                    end
                    else if (stat.row_cov || !stat.rd_zero)
                    begin
                        if (r_last) adv_col = 1'b1;
                        else r_next = r_reg + 1'b1;
                    end
                    else
                    begin
                        cmd.op = OP_PRIME;
                        if (!stat.row_star)
                        begin
                            state_next = S_AUG;
                        end
                        else
                        begin
                            fnd     = 1'b1;
                            adv_col = 1'b1;
                        end
                    end
                    if (adv_col)
                    begin
                        r_next = '0;
                        if (c_last)
                        begin
                            c_next     = '0;
                            found_next = 1'b0;
                            if (!fnd)
                            begin
                                state_next = S_ADJ_MIN;
                            end
                        end
                        else
                        begin
                            c_next     = c_reg + 1'b1;
                            found_next = fnd;
                        end
                    end
                end
            end
            S_ADJ_MIN:
            begin
                if (ph_reg == 2'd0)
                begin
                    if (r_reg == '0 && c_reg == '0)
                    begin
                        cmd.op = OP_MIN_INIT;
                    end
                    ph_next = 2'd1;
                end
                else
                begin
                    cmd.op  = OP_ADJ_MIN;
                    ph_next = 2'd0;
                    if (c_last)
                    begin
                        c_next = '0;
                        if (r_last)
                        begin
                            r_next     = '0;
                            state_next = S_ADJ_UPD;
                        end
                        else
                        begin
                            r_next = r_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            S_ADJ_UPD:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    cmd.op  = OP_ADJ_T;
                    ph_next = 2'd2;
                end
                else
                begin
                    cmd.op  = OP_ADJ_WR;
                    ph_next = 2'd0;
                    if (c_last)
                    begin
                        c_next = '0;
                        if (r_last)
                        begin
                            r_next     = '0;
                            found_next = 1'b0;
                            state_next = S_PRIME;
                        end
                        else
                        begin
                            r_next = r_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            S_AUG:
            begin
                cmd.op = OP_AUG_STEP;
                if (stat.map_v && stat.map_prime_v)
                begin
                    c_next = map_prime_col;
                end
                else
                begin
                    state_next = S_REB_CLR;
                end
            end
            S_REB_CLR:
            begin
                cmd.op     = OP_REB_CLR;
                r_next     = '0;
                c_next     = '0;
                state_next = S_REB;
            end
            S_REB:
            begin
                cmd.op = OP_REB;
                if (r_last)
                begin
                    r_next     = '0;
                    state_next = S_COUNT;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                cmd.out_addr = 1'b1;
                cmd.last     = r_last;
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else if (stat.out_free)
                begin
                    cmd.op  = OP_EMIT;
                    ph_next = 2'd0;
                    if (r_last)
                    begin
                        r_next     = '0;
                        c_next     = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            r_reg     <= '0;
            c_reg     <= '0;
            ph_reg    <= 2'd0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            ph_reg    <= ph_next;
            found_reg <= found_next;
        end
    end

endmodule

// File: src/rectangular_assignment_solver.sv
// Top level of the rectangular assignment solver: register port, controller
// and datapath. Depends on ras_pkg, ras_ctrl and ras_dp.
//
// Set rows_in_use and cols_in_use over the register port while the block is
// idle; a write restarts the matrix load at element (0,0). Only bits 4:0 of a
// write are kept; kept values of 0 act as 1 and above MAX_DIM act as MAX_DIM.
// Cost elements enter on the input channel in row-major order, one transfer
// per cycle, rows*cols transfers per problem. The input is not ready while
// the block solves or reports.
// After the last element the solver walks the matrix in the working-cost
// memory, which has one read and one write port: a reduction pass, then
// prime scans, adjust passes over the whole matrix, and augments, each a
// path walk followed by a rebuild of the covers over the rows.
// Then one result per row leaves the output register; the last result
// carries the total cost and last_row.
// A stalled receiver holds the current result and the solver waits.
// Reset returns both sizes to 16 and empties the load; no clearing pass.
module rectangular_assignment_solver
    import ras_pkg::*;
#(
    parameter int MAX_DIM   = 16,
    parameter int COST_BITS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] cost_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  row_index,
    output logic [3:0]  assigned_column,
    output logic        is_assigned,
    output logic [19:0] total_cost,
    output logic        last_row
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [4:0] rows_reg, cols_reg;
    logic cfg_wr;
    logic [DIM_W-1:0] nr, nc, min_dim;
    cmd_t cmd;
    stat_t stat;
    logic [IDX_W-1:0] r, c, map_prime_col;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COLS) ? {27'd0, cols_reg} : {27'd0, rows_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 5'd16;
            cols_reg <= 5'd16;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_ROWS)
            begin
                rows_reg <= pwdata[4:0];
            end
            else
            begin
                cols_reg <= pwdata[4:0];
            end
        end
    end

    assign nr = (rows_reg == 5'd0) ? DIM_W'(1) :
                (rows_reg > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_reg);
    assign nc = (cols_reg == 5'd0) ? DIM_W'(1) :
                (cols_reg > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_reg);

    ras_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .nr            (nr),
        .nc            (nc),
        .cfg_wr        (cfg_wr),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stat          (stat),
        .map_prime_col (map_prime_col),
        .cmd           (cmd),
        .r             (r),
        .c             (c),
        .min_dim       (min_dim)
    );

    ras_dp #(
        .MAX_DIM   (MAX_DIM),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .r               (r),
        .c               (c),
        .min_dim         (min_dim),
        .cost            (COST_BITS'(cost_value)),
        .stat            (stat),
        .map_prime_col   (map_prime_col),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .row_index       (row_index),
        .assigned_column (assigned_column),
        .is_assigned     (is_assigned),
        .total_cost      (total_cost),
        .last_row        (last_row)
    );

endmodule

// File: src/ras_checker.sv
// Port-level checks for the assignment solver, bound to the top level.
// Depends only on the top level's ports.
module ras_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  row_index,
    input logic [19:0] total_cost,
    input logic        last_row
);

    // A held result keeps its row and its last mark.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_index) && $stable(last_row))
        else $error("result changed while stalled");

    // No new input is taken while a solution is still being reported.
    a_no_load_mid_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_row |-> !in_ready)
        else $error("input ready during result transfer");

    // Only the last result of a solution carries a total.
    a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_row |-> total_cost == 20'd0)
        else $error("total on a non-final result");

    // Results of one solution come in ascending row order.
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_row |=>
        !out_valid || (row_index == $past(row_index) + 4'd1))
        else $error("row order broken");

endmodule

bind rectangular_assignment_solver ras_checker u_ras_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_index  (row_index),
    .total_cost (total_cost),
    .last_row   (last_row)
);

// File: dv/tb_rectangular_assignment_solver.sv
// Self-checking testbench for rectangular_assignment_solver: loads cost matrices of
// many shapes, predicts every row assignment with its own Munkres solver and checks.
// Depends on ras_pkg and the solver RTL only.
module tb_rectangular_assignment_solver;
    import ras_pkg::*;

    localparam int DIM = 16;
    localparam logic [2:0] ADDR_ROWS = 3'(REG_ROWS) << 2;
    localparam logic [2:0] ADDR_COLS = 3'(REG_COLS) << 2;
    localparam logic [23:0] WORK_SAT = 24'hFFFFFF;
    localparam int ITEM_GOAL = 480;
    localparam int QUIET_FROM = 420;
    localparam int PRESS_FROM = 360;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [3:0]  row;
        logic [3:0]  col;
        logic        assigned;
        logic [19:0] total;
        logic        last;
    } assign_t;

    typedef struct {
        bit          wr;
        logic [31:0] rows_val;
        logic [31:0] cols_val;
        logic [15:0] cost;
        bit          typed;
        logic [3:0]  exp_col;
        logic [19:0] exp_total;
    } vec_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] cost_value;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  row_index;
    logic [3:0]  assigned_column;
    logic        is_assigned;
    logic [19:0] total_cost;
    logic        last_row;

    rectangular_assignment_solver uut (.*);

    logic [15:0] orig_cost [DIM][DIM];
    logic [23:0] work_cost [DIM][DIM];
    bit          star [DIM][DIM];
    bit          prime [DIM][DIM];
    bit          row_cov [DIM];
    bit          col_cov [DIM];
    logic [4:0]  rows_reg;
    logic [4:0]  cols_reg;
    int          load_cnt;

    assign_t     expected_rows [$];
    int          errors;
    int          items_sent;
    bit          quiet_tail;
    longint      cycles;

    function automatic int clamp_dim(logic [4:0] v);
        if (v == 0) return 1;
        if (v > DIM) return DIM;
        return int'(v);
    endfunction

    function automatic int star_in_row(int r, int nc);
        for (int c = 0; c < nc; c++) if (star[r][c]) return c;
        return nc;
    endfunction

    function automatic int star_in_col(int c, int nr);
        for (int r = 0; r < nr; r++) if (star[r][c]) return r;
        return nr;
    endfunction

    function automatic void augment_path(int zr, int zc, int nr, int nc);
        bit nstar [DIM][DIM];
        int sr;
        int sc;
        int pc;
        nstar = star;
        nstar[zr][zc] = 1;
        sc = zc;
        sr = star_in_col(sc, nr);
        while (sr < nr) begin
            nstar[sr][sc] = 0;
            pc = nc;
            for (int c = 0; c < nc; c++)
                if (prime[sr][c]) begin
                    pc = c;
                    break;
                end
            if (pc >= nc) break;
            nstar[sr][pc] = 1;
            sc = pc;
            sr = star_in_col(sc, nr);
        end
        star = nstar;
        foreach (prime[r, c]) prime[r][c] = 0;
        foreach (row_cov[i]) row_cov[i] = 0;
        for (int c = 0; c < nc; c++) if (star_in_col(c, nr) < nr) col_cov[c] = 1;
    endfunction

    function automatic void adjust_by_min(int nr, int nc);
        logic [24:0] h;
        logic [24:0] v;
        h = WORK_SAT;
        for (int r = 0; r < nr; r++)
            if (!row_cov[r])
                for (int c = 0; c < nc; c++)
                    if (!col_cov[c] && work_cost[r][c] < h) h = work_cost[r][c];
        for (int r = 0; r < nr; r++)
            if (row_cov[r])
                for (int c = 0; c < nc; c++) begin
                    v = work_cost[r][c] + h;
                    work_cost[r][c] = (v > WORK_SAT) ? WORK_SAT : v[23:0];
                end
        for (int c = 0; c < nc; c++)
            if (!col_cov[c])
                for (int r = 0; r < nr; r++)
                    work_cost[r][c] = (work_cost[r][c] < h) ? 24'd0 : work_cost[r][c] - h[23:0];
    endfunction

    function automatic void solve_assignment(int nr, int nc);
        int min_dim;
        int covered;
        int sc;
        int zr;
        int zc;
        bit found;
        bit hit;
        logic [23:0] m;
        foreach (star[r, c]) begin
            star[r][c] = 0;
            prime[r][c] = 0;
            work_cost[r][c] = orig_cost[r][c];
        end
        foreach (row_cov[i]) begin
            row_cov[i] = 0;
            col_cov[i] = 0;
        end
        if (nr <= nc) begin
            min_dim = nr;
            for (int r = 0; r < nr; r++) begin
                m = work_cost[r][0];
                for (int c = 1; c < nc; c++) if (work_cost[r][c] < m) m = work_cost[r][c];
                for (int c = 0; c < nc; c++) work_cost[r][c] -= m;
            end
            for (int r = 0; r < nr; r++)
                for (int c = 0; c < nc; c++)
                    if (work_cost[r][c] == 0 && !col_cov[c]) begin
                        star[r][c] = 1;
                        col_cov[c] = 1;
                        break;
                    end
        end
        else begin
            min_dim = nc;
            for (int c = 0; c < nc; c++) begin
                m = work_cost[0][c];
                for (int r = 1; r < nr; r++) if (work_cost[r][c] < m) m = work_cost[r][c];
                for (int r = 0; r < nr; r++) work_cost[r][c] -= m;
            end
            for (int c = 0; c < nc; c++)
                for (int r = 0; r < nr; r++)
                    if (work_cost[r][c] == 0 && !row_cov[r]) begin
                        star[r][c] = 1;
                        col_cov[c] = 1;
                        row_cov[r] = 1;
                        break;
                    end
            foreach (row_cov[i]) row_cov[i] = 0;
        end
        forever begin
            covered = 0;
            for (int c = 0; c < nc; c++) if (col_cov[c]) covered++;
            if (covered >= min_dim) break;
            forever begin
                found = 1;
                hit = 0;
                zr = 0;
                zc = 0;
                while (found && !hit) begin
                    found = 0;
                    for (int c = 0; c < nc && !hit; c++) begin
                        if (col_cov[c]) continue;
                        for (int r = 0; r < nr; r++) begin
                            if (row_cov[r] || work_cost[r][c] != 0) continue;
                            prime[r][c] = 1;
                            sc = star_in_row(r, nc);
                            if (sc >= nc) begin
                                hit = 1;
                                zr = r;
                                zc = c;
                            end
                            else begin
                                row_cov[r] = 1;
                                col_cov[sc] = 0;
                                found = 1;
                            end
                            break;
                        end
                    end
                end
                if (hit) begin
                    augment_path(zr, zc, nr, nc);
                    break;
                end
                adjust_by_min(nr, nc);
            end
        end
    endfunction

    function automatic void take_cost(logic [15:0] v);
        int nr;
        int nc;
        int sc;
        logic [20:0] sum;
        assign_t a;
        nr = clamp_dim(rows_reg);
        nc = clamp_dim(cols_reg);
        if (load_cnt >= nr * nc) load_cnt = 0;
        orig_cost[load_cnt / nc][load_cnt % nc] = v;
        load_cnt++;
        if (load_cnt < nr * nc) return;
        load_cnt = 0;
        solve_assignment(nr, nc);
        sum = 0;
        for (int k = 0; k < nr; k++) begin
            sc = star_in_row(k, nc);
            a = '0;
            a.row = 4'(k);
            if (sc < nc) begin
                sum += orig_cost[k][sc];
                if (sum > TOTAL_MAX) sum = TOTAL_MAX;
                a.col = 4'(sc);
                a.assigned = 1;
            end
            if (k == nr - 1) begin
                a.total = sum[19:0];
                a.last = 1;
            end
            expected_rows.push_back(a);
        end
    endfunction

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (expected_rows.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr == ADDR_ROWS) rows_reg = data[4:0];
        else cols_reg = data[4:0];
        load_cnt = 0;
    endtask

    task automatic set_shape(logic [31:0] r, logic [31:0] c);
        in_valid <= 0;
        wait_idle();
        reg_write(ADDR_ROWS, r);
        reg_write(ADDR_COLS, c);
    endtask

    task automatic send_cost(logic [15:0] v);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1;
        cost_value <= v;
        do @(posedge clk); while (!in_ready);
        take_cost(v);
        items_sent++;
        if (items_sent >= QUIET_FROM) quiet_tail = 1;
    endtask

    function automatic logic [15:0] pick_cost(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 2));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_reg(int d);
        if (d == 1 && $urandom_range(0, 2) == 0) return 0;
        if (d == DIM) return $urandom_range(DIM, 31);
        return d;
    endfunction

    vec_t directed [] = '{
        '{1, 0, 0, 16'h0000, 1, 4'd0, 20'd0},
        '{0, 0, 0, 16'hFFFF, 1, 4'd0, 20'd65535},
        '{0, 0, 0, 16'h5555, 1, 4'd0, 20'h05555},
        '{0, 0, 0, 16'hAAAA, 1, 4'd0, 20'h0AAAA},
        '{1, 2, 1, 16'd5, 0, 0, 0},
        '{0, 0, 0, 16'd3, 0, 0, 0},
        '{1, 1, 3, 16'd9, 0, 0, 0},
        '{0, 0, 0, 16'd2, 0, 0, 0},
        '{0, 0, 0, 16'd7, 0, 0, 0},
        '{1, 2, 2, 16'd1, 0, 0, 0},
        '{0, 0, 0, 16'd2, 0, 0, 0},
        '{1, 2, 2, 16'd4, 0, 0, 0},
        '{0, 0, 0, 16'd1, 0, 0, 0},
        '{0, 0, 0, 16'd1, 0, 0, 0},
        '{0, 0, 0, 16'd4, 0, 0, 0},
        '{1, 3, 3, 16'd1, 0, 0, 0},
        '{0, 0, 0, 16'd2, 0, 0, 0},
        '{0, 0, 0, 16'd3, 0, 0, 0},
        '{0, 0, 0, 16'd2, 0, 0, 0},
        '{0, 0, 0, 16'd4, 0, 0, 0},
        '{0, 0, 0, 16'd6, 0, 0, 0},
        '{0, 0, 0, 16'd3, 0, 0, 0},
        '{0, 0, 0, 16'd6, 0, 0, 0},
        '{0, 0, 0, 16'd9, 0, 0, 0}
    };

    initial
    begin
        int nr;
        int nc;
        int mode;
        assign_t a;
        bit big_done;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_valid = 0;
        cost_value = '0;
        rows_reg = 5'd16;
        cols_reg = 5'd16;
        load_cnt = 0;
        errors = 0;
        items_sent = 0;
        quiet_tail = 0;
        big_done = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].wr) set_shape(directed[i].rows_val, directed[i].cols_val);
            send_cost(directed[i].cost);
            if (directed[i].typed)
            begin
                void'(expected_rows.pop_back());
                a = '{4'd0, directed[i].exp_col, 1'b1, directed[i].exp_total, 1'b1};
                expected_rows.push_back(a);
            end
        end

        while (items_sent < ITEM_GOAL)
        begin
            if (!big_done && items_sent > 60)
            begin
                nr = DIM;
                nc = DIM;
                big_done = 1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                nr = $urandom_range(1, DIM);
                nc = $urandom_range(1, 3);
                if ($urandom_range(0, 1)) {nr, nc} = {nc, nr};
            end
            else
            begin
                nr = $urandom_range(1, 5);
                nc = $urandom_range(1, 5);
            end
            set_shape(pick_reg(nr), pick_reg(nc));
            mode = $urandom_range(0, 2);
            do
            begin
                for (int k = 0; k < nr * nc; k++) send_cost(pick_cost(mode));
            end
            while (items_sent >= PRESS_FROM && items_sent < PRESS_FROM + 60);
        end
        in_valid <= 0;

        while (expected_rows.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        out_ready <= 1;
        while (items_sent < PRESS_FROM) @(posedge clk);
        out_ready <= 0;
        repeat (400) @(posedge clk);
        out_ready <= 1;
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ready <= 1;
            end
        end
    end

    always @(posedge clk)
    begin
        assign_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("unexpected result transfer for row %0d", row_index);
                errors++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (row_index !== want.row)
                begin
                    $error("row_index expected %0d actual %0d", want.row, row_index);
                    errors++;
                end
                if (assigned_column !== want.col)
                begin
                    $error("assigned_column expected %0d actual %0d", want.col, assigned_column);
                    errors++;
                end
                if (is_assigned !== want.assigned)
                begin
                    $error("is_assigned expected %0d actual %0d", want.assigned, is_assigned);
                    errors++;
                end
                if (total_cost !== want.total)
                begin
                    $error("total_cost expected %0d actual %0d", want.total, total_cost);
                    errors++;
                end
                if (last_row !== want.last)
                begin
                    $error("last_row expected %0d actual %0d", want.last, last_row);
                    errors++;
                end
            end
        end
    end

endmodule
